// ----- sv/pal_pkg.sv -----
// Shared codes and field widths for the positional array list.
`default_nettype none
package pal_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned REQ_W = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 5;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned CNT_W = 5;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FIND   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [ST_W-1:0] ST_POS_ZERO  = 3'd3;
  localparam logic [ST_W-1:0] ST_BEYOND    = 3'd4;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd5;

endpackage
`default_nettype wire

// ----- sv/pal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- sv/positional_array_list_core.sv -----
// Top level of the positional array list: request sequencer around the element RAM.
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+--------------------------
//  request  | req_type_i, value_i, position_i                | start & !busy
//  result   | status_o, found_position_o, read_value_o,      | done_o, one cycle, no stall
//           | count_o                                        |
//
// Clear, append, refused requests and unused codes finish at the accept edge:
// the result shows in the next cycle. Read, find, delete and insert step through the
// read, find or move state, insert then a final write state; the single RAM port
// pair moves one entry per cycle. Reset empties the list; store
// contents stay undefined until written. One transaction is in work at a time;
// the result side cannot stall.
`default_nettype none
module positional_array_list_core #(
  parameter int unsigned CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic        [pal_pkg::REQ_W-1:0]   req_type_i,
  input  wire logic signed [pal_pkg::VAL_W-1:0]   value_i,
  input  wire logic        [pal_pkg::POS_W-1:0]   position_i,
  output logic                                    done_o,
  output logic             [pal_pkg::ST_W-1:0]    status_o,
  output logic             [pal_pkg::POS_W-1:0]   found_position_o,
  output logic signed      [pal_pkg::VAL_W-1:0]   read_value_o,
  output logic             [pal_pkg::CNT_W-1:0]   count_o
);

  import pal_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_FIND   = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_INSFIN = 3'd4;

  function automatic logic [CNT_W-1:0] to_field(input logic [LW-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    return e[CNT_W-1:0];
  endfunction

  logic [2:0]       state_q, state_d;
  logic [LW-1:0]    len_q, len_d;
  logic             done_q, done_d;
  logic [ST_W-1:0]  status_q, status_d;
  logic [POS_W-1:0] found_q, found_d;
  logic [VAL_W-1:0] rdval_q, rdval_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic             ins_q, ins_d;
  logic [LW-1:0]    ptr_q, ptr_d;
  logic [LW-1:0]    rem_q, rem_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [LW-1:0]    cmp_idx_q, cmp_idx_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] rdata;

  logic [CW-1:0]    pos_ext, len_ext, pos_m1;
  logic [LW-1:0]    ptr_up, ptr_dn, cmp_idx_p1;
  logic             full, accept;

  assign pos_ext    = CW'(position_i);
  assign len_ext    = CW'(len_q);
  assign pos_m1     = pos_ext - CW'(1);
  assign full       = (len_q == LW'(CAPACITY));
  assign ptr_up     = ptr_q + LW'(1);
  assign ptr_dn     = ptr_q - LW'(1);
  assign cmp_idx_p1 = cmp_idx_q + LW'(1);
  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;

  pal_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    done_d      = 1'b0;
    status_d    = status_q;
    found_d     = found_q;
    rdval_d     = rdval_q;
    count_d     = count_q;
    val_d       = val_q;
    pos_d       = pos_q;
    ins_d       = ins_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    we          = 1'b0;
    waddr       = pend_addr_q;
    wdata       = rdata;
    raddr       = ptr_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d    = value_i;
          pos_d    = pos_m1[AW-1:0];
          status_d = ST_OK;
          found_d  = '0;
          rdval_d  = '0;
          case (req_type_i)
            REQ_CLEAR: begin
              len_d  = '0;
              done_d = 1'b1;
            end
            REQ_APPEND: begin
              done_d = 1'b1;
              if (full) begin
                status_d = ST_FULL;
              end else begin
                we    = 1'b1;
                waddr = len_q[AW-1:0];
                wdata = value_i;
                len_d = len_q + LW'(1);
              end
            end
            REQ_INSERT: begin
              if (full) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else if (position_i == '0) begin
                status_d = ST_POS_ZERO;
                done_d   = 1'b1;
              end else if (pos_m1 > len_ext) begin
                status_d = ST_BEYOND;
                done_d   = 1'b1;
              end else begin
                // shift entries pos-1..len-1 up, top first
                ins_d   = 1'b1;
                rem_d   = LW'(len_ext - pos_m1);
                ptr_d   = len_q - LW'(1);
                pend_d  = 1'b0;
                state_d = S_MOVE;
              end
            end
            REQ_DELETE: begin
              if (len_q == '0) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else if (position_i == '0) begin
                status_d = ST_POS_ZERO;
                done_d   = 1'b1;
              end else if (pos_ext > len_ext) begin
                status_d = ST_BEYOND;
                done_d   = 1'b1;
              end else begin
                // shift entries pos..len-1 down, bottom first
                ins_d   = 1'b0;
                rem_d   = LW'(len_ext - pos_ext);
                ptr_d   = LW'(pos_ext);
                pend_d  = 1'b0;
                state_d = S_MOVE;
              end
            end
            REQ_FIND: begin
              if (len_q == '0) begin
                status_d = ST_NOT_FOUND;
                done_d   = 1'b1;
              end else begin
                ptr_d     = '0;
                cmp_vld_d = 1'b0;
                state_d   = S_FIND;
              end
            end
            REQ_READ: begin
              if (position_i == '0) begin
                status_d = ST_POS_ZERO;
                done_d   = 1'b1;
              end else if (pos_ext > len_ext) begin
                status_d = ST_BEYOND;
                done_d   = 1'b1;
              end else begin
                raddr   = pos_m1[AW-1:0];
                state_d = S_READ;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        rdval_d = rdata;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_FIND: begin
        // issue one address per cycle, compare the entry issued the cycle before
        raddr     = ptr_q[AW-1:0];
        cmp_vld_d = (ptr_q != len_q);
        cmp_idx_d = ptr_q;
        if (ptr_q != len_q) begin
          ptr_d = ptr_up;
        end
        if (cmp_vld_q && (rdata == val_q)) begin
          found_d = to_field(cmp_idx_p1);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (cmp_vld_q && (ptr_q == len_q)) begin
          status_d = ST_NOT_FOUND;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_MOVE: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = pend_addr_q;
          wdata = rdata;
        end
        if (rem_q != '0) begin
          raddr       = ptr_q[AW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = ins_q ? ptr_up[AW-1:0] : ptr_dn[AW-1:0];
          ptr_d       = ins_q ? ptr_dn : ptr_up;
          rem_d       = rem_q - LW'(1);
        end else begin
          // the last moved entry lands at this edge
          pend_d = 1'b0;
          if (ins_q) begin
            state_d = S_INSFIN;
          end else begin
            len_d   = len_q - LW'(1);
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end

      S_INSFIN: begin
        we      = 1'b1;
        waddr   = pos_q;
        wdata   = val_q;
        len_d   = len_q + LW'(1);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done_d) begin
      count_d = to_field(len_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    found_q     <= found_d;
    rdval_q     <= rdval_d;
    count_q     <= count_d;
    val_q       <= val_d;
    pos_q       <= pos_d;
    ins_q       <= ins_d;
    ptr_q       <= ptr_d;
    rem_q       <= rem_d;
    cmp_vld_q   <= cmp_vld_d;
    cmp_idx_q   <= cmp_idx_d;
    pend_q      <= pend_d;
    pend_addr_q <= pend_addr_d;
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign found_position_o = found_q;
  assign read_value_o     = $signed(rdval_q);
  assign count_o          = count_q;

endmodule
`default_nettype wire

// ----- tb/positional_array_list_checker.sv -----
// Checker for the positional array list: predicts each result and compares it.
`timescale 1ns / 100ps
module positional_array_list_checker #(
  parameter int unsigned CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic        [pal_pkg::REQ_W-1:0]   req_type_i,
  input  logic signed [pal_pkg::VAL_W-1:0]   value_i,
  input  logic        [pal_pkg::POS_W-1:0]   position_i,
  input  logic                               done_i,
  input  logic        [pal_pkg::ST_W-1:0]    status_i,
  input  logic        [pal_pkg::POS_W-1:0]   found_position_i,
  input  logic signed [pal_pkg::VAL_W-1:0]   read_value_i,
  input  logic        [pal_pkg::CNT_W-1:0]   count_i,
  output int                                 errors_o,
  output int                                 pending_o,
  output int                                 list_length_o,
  output int                                 results_o,
  output int                                 fills_o,
  output int                                 empties_o
);
  import pal_pkg::*;

  typedef struct packed {
    logic        [ST_W-1:0]  status;
    logic        [POS_W-1:0] found;
    logic signed [VAL_W-1:0] rd;
    logic        [CNT_W-1:0] count;
  } list_result_t;

  logic signed [VAL_W-1:0] list_store [CAPACITY];
  int unsigned             list_len;
  list_result_t            expected_results [$];
  list_result_t            exp_res;
  int                      errors;
  int                      results;
  int                      fills;
  int                      empties;

  // Apply one request to the shadow list and return the result it yields.
  function automatic list_result_t apply_request(input logic [REQ_W-1:0] req,
                                                 input logic signed [VAL_W-1:0] val,
                                                 input logic [POS_W-1:0] pos);
    list_result_t res;
    int unsigned  k;
    int unsigned  p;
    int unsigned  prev_len;
    res = '0;
    res.status = ST_OK;
    p = pos;
    prev_len = list_len;
    case (req)
      REQ_CLEAR: list_len = 0;
      REQ_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_store[list_len] = val;
          list_len++;
        end
      end
      REQ_INSERT: begin
        // full takes priority over any position check
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (p == 0) begin
          res.status = ST_POS_ZERO;
        end else if (p - 1 > list_len) begin
          res.status = ST_BEYOND;
        end else begin
          for (k = list_len; k > p - 1; k--) list_store[k] = list_store[k-1];
          list_store[p-1] = val;
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p == 0) begin
          res.status = ST_POS_ZERO;
        end else if (p > list_len) begin
          res.status = ST_BEYOND;
        end else begin
          for (k = p - 1; k + 1 < list_len; k++) list_store[k] = list_store[k+1];
          list_len--;
        end
      end
      REQ_FIND: begin
        res.status = ST_NOT_FOUND;
        for (k = 0; k < list_len; k++) begin
          if (list_store[k] == val) begin
            res.status = ST_OK;
            res.found = POS_W'(k + 1);
            break;
          end
        end
      end
      REQ_READ: begin
        if (p == 0) begin
          res.status = ST_POS_ZERO;
        end else if (p > list_len) begin
          res.status = ST_BEYOND;
        end else begin
          res.rd = list_store[p-1];
        end
      end
      default: ;
    endcase
    if (list_len == CAPACITY && prev_len < CAPACITY) fills++;
    if (list_len == 0 && prev_len > 0) empties++;
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      expected_results.delete();
      errors = 0;
      results = 0;
      fills = 0;
      empties = 0;
    end else begin
      // Compare the result first: a new transaction never matches the oldest entry.
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction waiting: status %0d count %0d",
                 status_i, count_i);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          results++;
          if (status_i !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status_i);
            errors++;
          end
          if (found_position_i !== exp_res.found) begin
            $error("found_position: expected %0d, got %0d", exp_res.found,
                   found_position_i);
            errors++;
          end
          if (read_value_i !== exp_res.rd) begin
            $error("read_value: expected %0d, got %0d", exp_res.rd, read_value_i);
            errors++;
          end
          if (count_i !== exp_res.count) begin
            $error("count: expected %0d, got %0d", exp_res.count, count_i);
            errors++;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(apply_request(req_type_i, value_i, position_i));
      end
    end
    errors_o      <= errors;
    pending_o     <= expected_results.size();
    list_length_o <= list_len;
    results_o     <= results;
    fills_o       <= fills;
    empties_o     <= empties;
  end

endmodule

// ----- tb/positional_array_list_core_test.sv -----
// Top of the positional array list testbench: clock, reset, request stimulus, verdict.
`timescale 1ns / 100ps
module positional_array_list_core_test;
  import pal_pkg::*;

  localparam int unsigned CAPACITY     = CAPACITY_DEF;
  localparam int          RANDOM_ITEMS = 1850;
  localparam int          SETTLE       = 48;

  // request codes the block ignores
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic        [REQ_W-1:0]   req_type_i;
  logic signed [VAL_W-1:0]   value_i;
  logic        [POS_W-1:0]   position_i;
  logic                      done_o;
  logic        [ST_W-1:0]    status_o;
  logic        [POS_W-1:0]   found_position_o;
  logic signed [VAL_W-1:0]   read_value_o;
  logic        [CNT_W-1:0]   count_o;

  int errors;
  int pending;
  int list_length;
  int results;
  int fills;
  int empties;

  logic signed [VAL_W-1:0] value_pool [8];
  int                      requests_sent;
  int                      no_gap_left;
  bit                      growing;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  positional_array_list_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .read_value_o    (read_value_o),
    .count_o         (count_o)
  );

  positional_array_list_checker #(
    .CAPACITY(CAPACITY)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .done_i          (done_o),
    .status_i        (status_o),
    .found_position_i(found_position_o),
    .read_value_i    (read_value_o),
    .count_i         (count_o),
    .errors_o        (errors),
    .pending_o       (pending),
    .list_length_o   (list_length),
    .results_o       (results),
    .fills_o         (fills),
    .empties_o       (empties)
  );

  // Present one request after a random gap and hold it until accepted.
  task automatic send(input logic [REQ_W-1:0] req, input logic signed [VAL_W-1:0] val,
                      input logic [POS_W-1:0] pos);
    int gap;
    if (no_gap_left > 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 49) == 0) no_gap_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    position_i <= pos;
    do @(posedge clk_i); while (busy);
    requests_sent++;
  endtask

  // Hold off until every outstanding transaction has returned its result.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic next_random(output logic [REQ_W-1:0] req,
                             output logic signed [VAL_W-1:0] val,
                             output logic [POS_W-1:0] pos);
    int unsigned r;
    int unsigned hi;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      req = REQ_CLEAR;
    end else if (r < 4) begin
      req = ($urandom_range(0, 1) != 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
    end else if (r < 16) begin
      req = REQ_FIND;
    end else if (r < 28) begin
      req = REQ_READ;
    end else begin
      r = $urandom_range(0, 99);
      if (growing) req = (r < 45) ? REQ_APPEND : (r < 85) ? REQ_INSERT : REQ_DELETE;
      else         req = (r < 15) ? REQ_APPEND : (r < 30) ? REQ_INSERT : REQ_DELETE;
    end
    // mostly legal positions, with zero and arbitrary ones mixed in
    hi = (req == REQ_INSERT) ? list_length + 1 : ((list_length == 0) ? 1 : list_length);
    r = $urandom_range(0, 9);
    if (r == 0)      pos = '0;
    else if (r == 1) pos = POS_W'($urandom_range(0, 31));
    else             pos = POS_W'($urandom_range(1, hi));
    r = $urandom_range(0, 9);
    if (r < 4) begin
      val = value_pool[$urandom_range(0, 7)];
    end else if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       val = VAL_MIN;
        1:       val = VAL_MAX;
        2:       val = '0;
        default: val = -32'sd1;
      endcase
    end else begin
      val = $urandom;
    end
  endtask

  initial begin
    logic [REQ_W-1:0]   req;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]   pos;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    req_type_i    <= REQ_CLEAR;
    value_i       <= '0;
    position_i    <= '0;
    requests_sent = 0;
    no_gap_left   = 0;
    growing       = 1'b1;
    // small pool so finds hit and duplicates show up
    value_pool[0] = VAL_MIN;
    for (int i = 1; i < 8; i++) value_pool[i] = $urandom;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // refusals on an empty list
    send(REQ_READ,   '0, 5'd1);
    send(REQ_READ,   '0, 5'd0);
    send(REQ_DELETE, '0, 5'd1);
    send(REQ_FIND,   '0, 5'd0);
    send(REQ_INSERT, 32'sd7, 5'd2);
    send(REQ_INSERT, 32'sd7, 5'd0);
    // build a short list at the value extremes
    send(REQ_APPEND, VAL_MAX, 5'd0);
    send(REQ_APPEND, VAL_MIN, 5'd31);
    send(REQ_INSERT, -32'sd1, 5'd1);
    send(REQ_INSERT, '0, 5'd4);
    send(REQ_INSERT, 32'sd9, 5'd31);
    send(REQ_FIND,   VAL_MIN, 5'd0);
    send(REQ_FIND,   32'sd12345, 5'd0);
    send(REQ_READ,   '0, 5'd4);
    send(REQ_READ,   '0, 5'd31);
    send(REQ_READ,   '0, 5'd0);
    send(REQ_DELETE, '0, 5'd0);
    send(REQ_DELETE, '0, 5'd31);
    send(REQ_DELETE, '0, 5'd2);
    send(REQ_DELETE, '0, 5'd3);
    send(REQ_SPARE_LO, VAL_MAX, 5'd31);
    send(REQ_SPARE_HI, VAL_MIN, 5'd1);
    send(REQ_CLEAR, '0, 5'd0);
    drain();

    // fill to capacity, then overfill by append and insert
    for (int i = 0; i < CAPACITY; i++) send(REQ_APPEND, $urandom, POS_W'($urandom));
    send(REQ_APPEND, VAL_MAX, 5'd1);
    send(REQ_INSERT, VAL_MIN, 5'd0);
    send(REQ_INSERT, -32'sd1, 5'd31);
    send(REQ_FIND, '0, 5'd0);
    send(REQ_READ, '0, 5'(CAPACITY));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (growing && list_length >= CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (!growing && list_length == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      else if ($urandom_range(0, 59) == 0) growing = !growing;
      next_random(req, val, pos);
      send(req, val, pos);
      if ($urandom_range(0, 149) == 0) drain();
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked", requests_sent, results);
    $display("list reached capacity %0d times and was emptied by delete or clear %0d times",
             fills, empties);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout waiting for outstanding results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
